// ===== rtl/core/roc_pkg.sv =====
package roc_pkg;
	localparam int DEF_VALUE_BITS = 32;
	localparam int MAX_DIGITS = 32;
	localparam int DIG_IDX_W = 5;
	localparam int CNT_W = 6;

	localparam logic [1:0] CMD_FIRST = 2'd0;
	localparam logic [1:0] CMD_SECOND = 2'd1;
	localparam logic [1:0] CMD_EXEC = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_CHAR = 2'd1;
	localparam logic [1:0] ERR_DIV0 = 2'd2;

	localparam logic [1:0] REG_FIRST = 2'd0;
	localparam logic [1:0] REG_SECOND = 2'd1;
	localparam logic [1:0] REG_RESULT = 2'd2;
	localparam logic [1:0] REG_OP = 2'd3;

	typedef struct packed {
		logic digit;
		logic sel_second;
		logic exec_load;
		logic div_start;
		logic div_by_rb;
		logic take_quot;
		logic push_digit;
		logic pop_digit;
		logic clear_run;
	} roc_cmd_t;

	typedef struct packed {
		logic bad_seen;
		logic div_zero;
		logic need_div;
		logic div_done;
		logic mag_zero;
		logic cnt_one;
		logic cnt_full;
	} roc_sts_t;

	function automatic logic [4:0] char_to_digit(input logic [7:0] ch);
		logic [4:0] d;
		d = 5'd31;
		if (ch >= 8'd48 && ch <= 8'd57) d = 5'(ch - 8'd48);
		else if (ch >= 8'd65 && ch <= 8'd70) d = 5'(ch - 8'd55);
		else if (ch >= 8'd97 && ch <= 8'd102) d = 5'(ch - 8'd87);
		return d;
	endfunction

	function automatic logic [7:0] digit_to_char(input logic [5:0] d);
		return (d < 6'd10) ? 8'(d + 6'd48) : 8'({2'b00, d} + 8'd55);
	endfunction
endpackage

// ===== rtl/core/radix_operand_calculator.sv =====
// radix_operand_calculator
// Command channel: start/busy with command and digit_char; a transfer happens
// when start is high and busy is low. Commands 0 and 1 add one ASCII digit to
// the first or second operand (no result). Command 2 executes the
// configured operation and sends the result digits in result_base, most
// significant first, one per strobe cycle with last on the final one.
// Errors (bad character, divide by zero) give one strobe with error_code set
// and out_char 0, on the cycle after the transfer.
// Each result digit costs one pass of the shared restoring divider, and a
// divide adds one more pass. Digits are then sent one per strobe, with a
// read state between strobes. busy stays high for the whole execute.
// Results are strobes; the receiver cannot stall and must take each one.
// Configuration: APB, registers first_base, second_base, result_base,
// operation at byte addresses 0, 4, 8, 12. Reset (arst_n low) sets bases to
// 10, operation to add and clears both operands and the error flag.
module radix_operand_calculator
	import roc_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  digit_char,
	output logic        strobe,
	output logic [7:0]  out_char,
	output logic        negative,
	output logic [1:0]  error_code,
	output logic        last
);
	logic [4:0] first_base_q, second_base_q;
	logic [5:0] result_base_q;
	logic [1:0] operation_q;
	roc_cmd_t cmd;
	roc_sts_t sts;
	logic [7:0] dp_char;
	logic dp_neg;
	logic [1:0] err;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_base_q <= 5'd10;
			second_base_q <= 5'd10;
			result_base_q <= 6'd10;
			operation_q <= OP_ADD;
		end else if (wr) begin
			case (paddr[3:2])
				REG_FIRST: first_base_q <= pwdata[4:0];
				REG_SECOND: second_base_q <= pwdata[4:0];
				REG_RESULT: result_base_q <= pwdata[5:0];
				REG_OP: operation_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FIRST: prdata = {27'd0, first_base_q};
			REG_SECOND: prdata = {27'd0, second_base_q};
			REG_RESULT: prdata = {26'd0, result_base_q};
			REG_OP: prdata = {30'd0, operation_q};
			default: prdata = '0;
		endcase
	end

	roc_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.sts(sts), .cmd(cmd), .busy(busy), .valid(strobe), .err(err), .last(last)
	);

	roc_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .digit_char(digit_char),
		.first_base(first_base_q), .second_base(second_base_q),
		.result_base(result_base_q), .operation(operation_q),
		.sts(sts), .out_char(dp_char), .negative(dp_neg)
	);

	assign error_code = err;
	assign out_char = (err != ERR_OK) ? 8'd0 : dp_char;
	assign negative = (err != ERR_OK) ? 1'b0 : dp_neg;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && error_code != ERR_OK) |-> last)
		else $error("error strobe without last");
	a_err_char: assert property (@(posedge clk) disable iff (!arst_n)
		(error_code != ERR_OK) |-> (strobe && out_char == 8'd0))
		else $error("error code off strobe");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && error_code == ERR_OK && last) |=> !strobe)
		else $error("strobe after last");
endmodule

// ===== rtl/core/roc_divider.sv =====
module roc_divider
	import roc_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [VALUE_BITS-1:0] remainder
);
	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] quo_q, rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic run_q, done_q;
	logic [VALUE_BITS:0] trial;
	logic [VALUE_BITS:0] shifted;

	assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(VALUE_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[VALUE_BITS]) begin
				rem_q <= trial[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

// ===== rtl/core/roc_datapath.sv =====
module roc_datapath
	import roc_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  roc_cmd_t        cmd,
	input  logic [7:0]      digit_char,
	input  logic [4:0]      first_base,
	input  logic [4:0]      second_base,
	input  logic [5:0]      result_base,
	input  logic [1:0]      operation,
	output roc_sts_t        sts,
	output logic [7:0]      out_char,
	output logic            negative
);
	localparam int VB = VALUE_BITS;

	logic [VB-1:0] first_q, second_q, mag_q;
	logic bad_q, neg_q, sq_neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [5:0] store_q [MAX_DIGITS];
	logic [5:0] rd_q;

	logic [4:0] radix, d;
	logic [VB-1:0] acc, acc_next, a_mag, b_mag, r, div_a, div_b, quo, rem, quo_signed;
	logic [5:0] rb;
	logic a_neg, b_neg, r_neg;
	logic div_done;

	assign radix = cmd.sel_second ?
		((second_base < 5'd2) ? 5'd2 : (second_base > 5'd16) ? 5'd16 : second_base) :
		((first_base < 5'd2) ? 5'd2 : (first_base > 5'd16) ? 5'd16 : first_base);
	assign rb = (result_base < 6'd2) ? 6'd2 : (result_base > 6'd36) ? 6'd36 : result_base;
	assign d = char_to_digit(digit_char);
	assign acc = cmd.sel_second ? second_q : first_q;
	assign acc_next = VB'(acc * VB'(radix)) + VB'(d);

	assign a_neg = first_q[VB-1];
	assign b_neg = second_q[VB-1];
	assign a_mag = a_neg ? VB'(-first_q) : first_q;
	assign b_mag = b_neg ? VB'(-second_q) : second_q;

	always_comb begin
		case (operation)
			OP_ADD: r = first_q + second_q;
			OP_SUB: r = first_q - second_q;
			OP_MUL: r = VB'(first_q * second_q);
			default: r = first_q;
		endcase
	end
	assign r_neg = r[VB-1];

	// signed quotient; its magnitude is the unsigned quotient itself
	assign quo_signed = sq_neg_q ? VB'(-quo) : quo;

	assign div_a = cmd.div_by_rb ? mag_q : a_mag;
	assign div_b = cmd.div_by_rb ? VB'(rb) : b_mag;

	roc_divider #(.VALUE_BITS(VB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_a), .divisor(div_b),
		.done(div_done), .quotient(quo), .remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			second_q <= '0;
			bad_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.clear_run) begin
			first_q <= '0;
			second_q <= '0;
			bad_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cmd.digit) begin
				if (d >= radix) bad_q <= 1'b1;
				else if (cmd.sel_second) second_q <= acc_next;
				else first_q <= acc_next;
			end
			if (cmd.push_digit && !sts.cnt_full) cnt_q <= cnt_q + 1'b1;
			if (cmd.pop_digit) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_load) begin
			mag_q <= r_neg ? VB'(-r) : r;
			neg_q <= r_neg;
			sq_neg_q <= a_neg ^ b_neg;
		end else if (cmd.take_quot) begin
			mag_q <= quo;
			neg_q <= quo_signed[VB-1];
		end else if (cmd.push_digit) begin
			mag_q <= quo;
		end
		if (cmd.push_digit && !sts.cnt_full)
			store_q[cnt_q[DIG_IDX_W-1:0]] <= rem[5:0];
		rd_q <= store_q[DIG_IDX_W'(cnt_q - 1'b1)];
	end

	assign sts.bad_seen = bad_q;
	assign sts.div_zero = (second_q == '0);
	assign sts.need_div = (operation == OP_DIV);
	assign sts.div_done = div_done;
	assign sts.mag_zero = (mag_q == '0);
	assign sts.cnt_one = (cnt_q == CNT_W'(1));
	assign sts.cnt_full = (cnt_q == CNT_W'(MAX_DIGITS));
	assign out_char = digit_to_char(rd_q);
	assign negative = neg_q;
endmodule

// ===== rtl/core/roc_controller.sv =====
module roc_controller
	import roc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  roc_sts_t   sts,
	output roc_cmd_t   cmd,
	output logic       busy,
	output logic       valid,
	output logic [1:0] err,
	output logic       last
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_QDIV = 3'd1;
	localparam logic [2:0] S_QWAIT = 3'd2;
	localparam logic [2:0] S_RDIV = 3'd3;
	localparam logic [2:0] S_RWAIT = 3'd4;
	localparam logic [2:0] S_READ = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0] state_q, state_d;
	logic valid_q, last_q;
	logic [1:0] err_q;
	logic go;

	assign go = start && !busy;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.sel_second = (command == CMD_SECOND);
		case (state_q)
			S_IDLE: begin
				if (go && (command == CMD_FIRST || command == CMD_SECOND)) cmd.digit = 1'b1;
				if (go && command == CMD_EXEC) begin
					if (sts.bad_seen || (sts.need_div && sts.div_zero)) begin
						cmd.clear_run = 1'b1;
					end else begin
						cmd.exec_load = 1'b1;
						if (sts.need_div) begin
							cmd.div_start = 1'b1;
							state_d = S_QWAIT;
						end else begin
							state_d = S_RDIV;
						end
					end
				end
			end
			S_QWAIT: if (sts.div_done) begin
				cmd.take_quot = 1'b1;
				state_d = S_RDIV;
			end
			S_RDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_by_rb = 1'b1;
				state_d = S_RWAIT;
			end
			S_RWAIT: if (sts.div_done) begin
				cmd.push_digit = 1'b1;
				state_d = S_QDIV;
			end
			S_QDIV: state_d = sts.mag_zero ? S_READ : S_RDIV;
			S_READ: state_d = S_EMIT;
			S_EMIT: begin
				if (sts.cnt_one) begin
					cmd.clear_run = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.pop_digit = 1'b1;
					state_d = S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			err_q <= ERR_OK;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= 1'b0;
			err_q <= ERR_OK;
			last_q <= 1'b0;
			if (state_q == S_IDLE && go && command == CMD_EXEC) begin
				if (sts.bad_seen) begin
					valid_q <= 1'b1; err_q <= ERR_CHAR; last_q <= 1'b1;
				end else if (sts.need_div && sts.div_zero) begin
					valid_q <= 1'b1; err_q <= ERR_DIV0; last_q <= 1'b1;
				end
			end
		end
	end

	assign valid = valid_q || (state_q == S_EMIT);
	assign err = err_q;
	assign last = last_q || (state_q == S_EMIT && sts.cnt_one);
endmodule
